// File: src/snm_pkg.sv
`default_nettype none
package snm_pkg;

  localparam int MAX_BOXES = 64;
  localparam int AW        = $clog2(MAX_BOXES);
  localparam int CW        = $clog2(MAX_BOXES + 1);

  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_SCORE_THR = 2'd0;
  localparam logic [1:0] REG_OVL_THR   = 2'd1;
  localparam logic [1:0] REG_AGNOSTIC  = 2'd2;

  localparam logic [15:0] SCORE_THR_RST = 16'd16384;
  localparam logic [15:0] OVL_THR_RST   = 16'd14746;

  localparam int OUT_DEPTH = 2;
  localparam int OUT_PW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // cross-multiply operands are fed 16 bits a cycle
  localparam int XY_W   = 64;
  localparam int CHUNKS = XY_W / 16;
  localparam int CK_W   = $clog2(CHUNKS);
  localparam int ACC_W  = 101;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] score;
    logic [7:0]  cls;
  } box_t;

  typedef struct packed {
    box_t box;
    logic eol;
    logic none;
    logic ovf;
  } res_t;

  typedef struct packed {
    logic [CW-1:0] n;
    logic          ovf;
  } desc_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    box_t          data;
  } wr_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RK_RD,
    BK_RK_LAT,
    BK_RK_SCAN,
    BK_RK_WR,
    BK_SP_RD,
    BK_SP_LAT,
    BK_SP_JRD,
    BK_SP_JLAT,
    BK_SP_WAIT,
    BK_OT_RD,
    BK_OT_PUSH,
    BK_OT_NONE
  } back_state_e;

  typedef enum logic [2:0] {
    D_IDLE,
    D_EDGE,
    D_MUL,
    D_SUM,
    D_THR,
    D_XY,
    D_ACC,
    D_CMP
  } diou_state_e;

endpackage
`default_nettype wire

// File: src/snm_ram.sv
`default_nettype none
module snm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/snm_front.sv
`default_nettype none
module snm_front import snm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [15:0] center_x_i,
  input  wire logic [15:0] center_y_i,
  input  wire logic [15:0] box_width_i,
  input  wire logic [15:0] box_height_i,
  input  wire logic [15:0] score_i,
  input  wire logic [7:0]  class_id_i,
  input  wire logic        last_i,
  input  wire logic [15:0] score_thr_i,
  output wr_t              store_wr_o,
  output logic             desc_valid_o,
  output desc_t            desc_o,
  input  wire logic        desc_pop_i
);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          dv_q, dv_d;
  desc_t         desc_q, desc_d;
  logic          acc, pass, room;

  // store is owned by the back end until it pops the frame
  assign full_o = dv_q;
  assign acc    = push_i & ~dv_q;
  assign pass   = (score_i != 16'd0) && (score_i >= score_thr_i);
  assign room   = cnt_q < CW'(MAX_BOXES);

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    dv_d   = dv_q & ~desc_pop_i;
    desc_d = desc_q;
    store_wr_o.we   = acc & pass & room;
    store_wr_o.addr = cnt_q[AW-1:0];
    store_wr_o.data = '{cx: center_x_i, cy: center_y_i, w: box_width_i,
                        h: box_height_i, score: score_i, cls: class_id_i};
    if (acc && pass) begin
      if (room) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (acc && last_i) begin
      dv_d       = 1'b1;
      desc_d.n   = cnt_d;
      desc_d.ovf = ovf_d;
      cnt_d      = '0;
      ovf_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      dv_q   <= 1'b0;
      desc_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      dv_q   <= dv_d;
      desc_q <= desc_d;
    end
  end

  assign desc_valid_o = dv_q;
  assign desc_o       = desc_q;

endmodule
`default_nettype wire

// File: src/snm_diou.sv
`default_nettype none
module snm_diou import snm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire box_t               a_i,
  input  wire box_t               b_i,
  input  wire logic signed [15:0] thr_i,
  output logic                    done_o,
  output logic                    hit_o
);

  diou_state_e state_q, state_d;
  logic [CK_W-1:0] ck_q, ck_d;

  box_t               a_q, b_q;
  logic signed [19:0] iw_q, ih_q;
  logic [17:0]        cw_q, ch_q;
  logic [16:0]        dx_q, dy_q;
  logic               disj_q, zero_q;
  logic [33:0]        inter_q, dx2_q, dy2_q;
  logic [31:0]        aa_q, ab_q;
  logic [35:0]        cw2_q, ch2_q, uni_q;
  logic [36:0]        cdiag_q;
  logic [34:0]        dist_q;
  logic [51:0]        tu_q;
  logic [52:0]        tc_q;
  logic [XY_W-1:0]    x_q, y_q;
  logic [ACC_W-1:0]   p_q, q_q;

  logic signed [19:0] la, ra, ta, bta, lb, rb, tb, btb, iw, ih, cw, ch;
  logic [15:0]        adx, ady, tabs;
  logic [52:0]        pp;
  logic [51:0]        qq;

  // edges in 1/32 pixel: 2*centre -/+ size
  always_comb begin
    la  = signed'({3'b0, a_q.cx, 1'b0}) - signed'({4'b0, a_q.w});
    ra  = signed'({3'b0, a_q.cx, 1'b0}) + signed'({4'b0, a_q.w});
    ta  = signed'({3'b0, a_q.cy, 1'b0}) - signed'({4'b0, a_q.h});
    bta = signed'({3'b0, a_q.cy, 1'b0}) + signed'({4'b0, a_q.h});
    lb  = signed'({3'b0, b_q.cx, 1'b0}) - signed'({4'b0, b_q.w});
    rb  = signed'({3'b0, b_q.cx, 1'b0}) + signed'({4'b0, b_q.w});
    tb  = signed'({3'b0, b_q.cy, 1'b0}) - signed'({4'b0, b_q.h});
    btb = signed'({3'b0, b_q.cy, 1'b0}) + signed'({4'b0, b_q.h});
    iw  = ((ra < rb) ? ra : rb) - ((la > lb) ? la : lb);
    ih  = ((bta < btb) ? bta : btb) - ((ta > tb) ? ta : tb);
    cw  = ((ra > rb) ? ra : rb) - ((la < lb) ? la : lb);
    ch  = ((bta > btb) ? bta : btb) - ((ta < tb) ? ta : tb);
    adx = (a_q.cx >= b_q.cx) ? a_q.cx - b_q.cx : b_q.cx - a_q.cx;
    ady = (a_q.cy >= b_q.cy) ? a_q.cy - b_q.cy : b_q.cy - a_q.cy;
    tabs = thr_i[15] ? 16'(~thr_i + 16'sd1) : 16'(thr_i);
    pp  = cdiag_q * x_q[XY_W-1 -: 16];
    qq  = uni_q * y_q[XY_W-1 -: 16];
  end

  always_comb begin
    state_d = state_q;
    ck_d    = ck_q;
    done_o  = 1'b0;
    hit_o   = (disj_q | zero_q) ? thr_i[15] : (p_q > q_q);
    unique case (state_q)
      D_IDLE: if (start_i) state_d = D_EDGE;
      D_EDGE: state_d = D_MUL;
      D_MUL:  state_d = D_SUM;
      D_SUM:  state_d = D_THR;
      D_THR:  state_d = D_XY;
      D_XY: begin
        ck_d    = '0;
        state_d = D_ACC;
      end
      D_ACC: begin
        ck_d = ck_q + CK_W'(1);
        if (ck_q == CK_W'(CHUNKS - 1)) state_d = D_CMP;
      end
      D_CMP: begin
        done_o  = 1'b1;
        state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      ck_q    <= '0;
    end else begin
      state_q <= state_d;
      ck_q    <= ck_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          a_q <= a_i;
          b_q <= b_i;
        end
      end
      D_EDGE: begin
        iw_q   <= iw;
        ih_q   <= ih;
        cw_q   <= cw[17:0];
        ch_q   <= ch[17:0];
        dx_q   <= {adx, 1'b0};
        dy_q   <= {ady, 1'b0};
        disj_q <= iw[19] | ih[19];
      end
      D_MUL: begin
        inter_q <= iw_q[16:0] * ih_q[16:0];
        aa_q    <= a_q.w * a_q.h;
        ab_q    <= b_q.w * b_q.h;
        cw2_q   <= cw_q * cw_q;
        ch2_q   <= ch_q * ch_q;
        dx2_q   <= dx_q * dx_q;
        dy2_q   <= dy_q * dy_q;
      end
      D_SUM: begin
        uni_q   <= 36'({aa_q, 2'b0}) + 36'({ab_q, 2'b0}) - 36'(inter_q);
        cdiag_q <= 37'(cw2_q) + 37'(ch2_q);
        dist_q  <= 35'(dx2_q) + 35'(dy2_q);
      end
      D_THR: begin
        tu_q   <= tabs * uni_q;
        tc_q   <= tabs * cdiag_q;
        zero_q <= (uni_q == 36'd0);
      end
      D_XY: begin
        x_q <= XY_W'({inter_q, 15'b0}) + (thr_i[15] ? XY_W'(tu_q) : '0);
        y_q <= XY_W'({dist_q, 15'b0}) + (thr_i[15] ? '0 : XY_W'(tc_q));
        p_q <= '0;
        q_q <= '0;
      end
      D_ACC: begin
        p_q <= {p_q[ACC_W-17:0], 16'b0} + ACC_W'(pp);
        q_q <= {q_q[ACC_W-17:0], 16'b0} + ACC_W'(qq);
        x_q <= {x_q[XY_W-17:0], 16'b0};
        y_q <= {y_q[XY_W-17:0], 16'b0};
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: src/snm_out_fifo.sv
`default_nettype none
module snm_out_fifo import snm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output res_t      data_o
);

  res_t              mem_q [OUT_DEPTH];
  logic [OUT_PW-1:0] wp_q, rp_q;
  logic [OUT_CW-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == OUT_CW'(OUT_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + OUT_PW'(1);
      if (do_pop)  rp_q <= rp_q + OUT_PW'(1);
      cnt_q <= cnt_q + OUT_CW'(do_push) - OUT_CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

// File: src/snm_back.sv
`default_nettype none
module snm_back import snm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               desc_valid_i,
  input  wire desc_t              desc_i,
  output logic                    desc_pop_o,
  output logic [AW-1:0]           store_raddr_o,
  input  wire box_t               store_rdata_i,
  input  wire logic signed [15:0] ovl_thr_i,
  input  wire logic               agnostic_i,
  output logic                    out_push_o,
  output res_t                    out_data_o,
  input  wire logic               out_full_i
);

  back_state_e state_q, state_d;
  logic [CW-1:0]        n_q, n_d, i_q, i_d, j_q, j_d, surv_q, surv_d, emit_q, emit_d;
  logic [AW-1:0]        rank_q, rank_d, rj_q, rj_d;
  logic                 rv_q, rv_d, ovf_q, ovf_d;
  logic [MAX_BOXES-1:0] marks_q, marks_d;
  box_t                 ent_q, ent_d, a_q, a_d;

  wr_t           srt_wr;
  logic [AW-1:0] srt_raddr;
  box_t          srt_rdata;
  logic          d_start, d_done, d_hit;
  logic [AW-1:0] i_a, j_a;

  assign i_a = i_q[AW-1:0];
  assign j_a = j_q[AW-1:0];

  snm_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_sorted (
    .clk_i   (clk_i),
    .we_i    (srt_wr.we),
    .waddr_i (srt_wr.addr),
    .wdata_i (srt_wr.data),
    .raddr_i (srt_raddr),
    .rdata_o (srt_rdata)
  );

  snm_diou u_diou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (d_start),
    .a_i     (a_q),
    .b_i     (srt_rdata),
    .thr_i   (ovl_thr_i),
    .done_o  (d_done),
    .hit_o   (d_hit)
  );

  always_comb begin
    state_d = state_q;
    n_d = n_q; i_d = i_q; j_d = j_q; surv_d = surv_q; emit_d = emit_q;
    rank_d = rank_q; rj_d = rj_q; rv_d = 1'b0; ovf_d = ovf_q;
    marks_d = marks_q; ent_d = ent_q; a_d = a_q;
    desc_pop_o    = 1'b0;
    store_raddr_o = i_a;
    srt_raddr     = i_a;
    srt_wr        = '{we: 1'b0, addr: rank_q, data: ent_q};
    d_start       = 1'b0;
    out_push_o    = 1'b0;
    out_data_o    = '{box: srt_rdata, eol: (emit_q + CW'(1)) == surv_q,
                      none: 1'b0, ovf: ovf_q};
    unique case (state_q)
      BK_IDLE: begin
        if (desc_valid_i) begin
          n_d     = desc_i.n;
          ovf_d   = desc_i.ovf;
          surv_d  = desc_i.n;
          emit_d  = '0;
          i_d     = '0;
          marks_d = '0;
          if (desc_i.n == '0) begin
            desc_pop_o = 1'b1;
            state_d    = BK_OT_NONE;
          end else begin
            state_d = BK_RK_RD;
          end
        end
      end
      // rank of box i: boxes with a higher score, or equal score and earlier arrival
      BK_RK_RD: state_d = BK_RK_LAT;
      BK_RK_LAT: begin
        ent_d   = store_rdata_i;
        rank_d  = '0;
        j_d     = '0;
        state_d = BK_RK_SCAN;
      end
      BK_RK_SCAN: begin
        if (rv_q && ((store_rdata_i.score > ent_q.score) ||
            (store_rdata_i.score == ent_q.score && CW'(rj_q) < i_q))) begin
          rank_d = rank_q + AW'(1);
        end
        if (j_q != n_q) begin
          store_raddr_o = j_a;
          rv_d = 1'b1;
          rj_d = j_a;
          j_d  = j_q + CW'(1);
        end else if (!rv_q) begin
          state_d = BK_RK_WR;
        end
      end
      BK_RK_WR: begin
        srt_wr.we = 1'b1;
        if (i_q + CW'(1) == n_q) begin
          desc_pop_o = 1'b1;
          i_d        = '0;
          state_d    = BK_SP_RD;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = BK_RK_RD;
        end
      end
      BK_SP_RD: begin
        if (i_q == n_q) begin
          i_d     = '0;
          state_d = BK_OT_RD;
        end else if (marks_q[i_a]) begin
          i_d = i_q + CW'(1);
        end else begin
          state_d = BK_SP_LAT;
        end
      end
      BK_SP_LAT: begin
        a_d     = srt_rdata;
        j_d     = i_q + CW'(1);
        state_d = BK_SP_JRD;
      end
      BK_SP_JRD: begin
        srt_raddr = j_a;
        if (j_q == n_q) begin
          i_d     = i_q + CW'(1);
          state_d = BK_SP_RD;
        end else if (marks_q[j_a]) begin
          j_d = j_q + CW'(1);
        end else begin
          state_d = BK_SP_JLAT;
        end
      end
      BK_SP_JLAT: begin
        srt_raddr = j_a;
        if (agnostic_i || a_q.cls == srt_rdata.cls) begin
          d_start = 1'b1;
          state_d = BK_SP_WAIT;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = BK_SP_JRD;
        end
      end
      BK_SP_WAIT: begin
        srt_raddr = j_a;
        if (d_done) begin
          if (d_hit) begin
            marks_d[j_a] = 1'b1;
            surv_d       = surv_q - CW'(1);
          end
          j_d     = j_q + CW'(1);
          state_d = BK_SP_JRD;
        end
      end
      BK_OT_RD: begin
        if (i_q == n_q) begin
          state_d = BK_IDLE;
        end else if (marks_q[i_a]) begin
          i_d = i_q + CW'(1);
        end else begin
          state_d = BK_OT_PUSH;
        end
      end
      BK_OT_PUSH: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          emit_d     = emit_q + CW'(1);
          i_d        = i_q + CW'(1);
          state_d    = BK_OT_RD;
        end
      end
      BK_OT_NONE: begin
        out_data_o = '{box: '0, eol: 1'b1, none: 1'b1, ovf: ovf_q};
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      surv_q  <= '0;
      emit_q  <= '0;
      rank_q  <= '0;
      rj_q    <= '0;
      rv_q    <= 1'b0;
      ovf_q   <= 1'b0;
      marks_q <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      surv_q  <= surv_d;
      emit_q  <= emit_d;
      rank_q  <= rank_d;
      rj_q    <= rj_d;
      rv_q    <= rv_d;
      ovf_q   <= ovf_d;
      marks_q <= marks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    a_q   <= a_d;
  end

endmodule
`default_nettype wire

// File: src/score_filter_diou_nms.sv
// Score-filtered DIoU non-maximum suppression, one frame at a time.
// Input channel (push/full): one candidate box per cycle while full is low. Boxes
// with a nonzero score at or above the score threshold go into a 64-entry store;
// extra passing boxes set the overflow flag. The box with last set closes the frame.
// After last, full stays high until the store has been ranked, one store read per
// cycle through the rank scan. Suppression then runs on a sorted copy while the
// next frame loads; the DIoU unit tests each same-class pair of surviving boxes,
// or every pair of surviving boxes in class-agnostic mode.
// Result channel (empty/pop): survivors in score order, end_of_list on the last;
// a frame with no survivor gives one word with none_kept set. A two-word output
// queue lets the back end run ahead; a stalled receiver stalls the back end and,
// once the next frame is closed, the input.
// APB registers: 0x0 score threshold, 0x4 overlap threshold, 0x8 class agnostic.
// Write them only while idle. Reset empties the store and the queues and loads
// the register defaults.
`default_nettype none
module score_filter_diou_nms import snm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [15:0]       center_x_i,
  input  wire logic [15:0]       center_y_i,
  input  wire logic [15:0]       box_width_i,
  input  wire logic [15:0]       box_height_i,
  input  wire logic [15:0]       score_i,
  input  wire logic [7:0]        class_id_i,
  input  wire logic              last_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic      [15:0]       out_center_x_o,
  output logic      [15:0]       out_center_y_o,
  output logic      [15:0]       out_width_o,
  output logic      [15:0]       out_height_o,
  output logic      [15:0]       out_score_o,
  output logic      [7:0]        out_class_o,
  output logic                   end_of_list_o,
  output logic                   none_kept_o,
  output logic                   overflowed_o
);

  logic [15:0] score_thr_q;
  logic [15:0] ovl_thr_q;
  logic        agn_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  wr_t           store_wr;
  logic [AW-1:0] store_raddr;
  box_t          store_rdata;
  logic          desc_valid, desc_pop, out_push, out_full;
  desc_t         desc;
  res_t          out_data, head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      REG_SCORE_THR: prdata = {16'b0, score_thr_q};
      REG_OVL_THR:   prdata = {16'b0, ovl_thr_q};
      REG_AGNOSTIC:  prdata = {31'b0, agn_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_thr_q <= SCORE_THR_RST;
      ovl_thr_q   <= OVL_THR_RST;
      agn_q       <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SCORE_THR: score_thr_q <= pwdata[15:0];
        REG_OVL_THR:   ovl_thr_q   <= pwdata[15:0];
        REG_AGNOSTIC:  agn_q       <= pwdata[0];
        default: ;
      endcase
    end
  end

  snm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .score_i      (score_i),
    .class_id_i   (class_id_i),
    .last_i       (last_i),
    .score_thr_i  (score_thr_q),
    .store_wr_o   (store_wr),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .desc_pop_i   (desc_pop)
  );

  snm_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_wr.we),
    .waddr_i (store_wr.addr),
    .wdata_i (store_wr.data),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  snm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .desc_valid_i  (desc_valid),
    .desc_i        (desc),
    .desc_pop_o    (desc_pop),
    .store_raddr_o (store_raddr),
    .store_rdata_i (store_rdata),
    .ovl_thr_i     (signed'(ovl_thr_q)),
    .agnostic_i    (agn_q),
    .out_push_o    (out_push),
    .out_data_o    (out_data),
    .out_full_i    (out_full)
  );

  snm_out_fifo u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_data),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head)
  );

  assign out_center_x_o = head.box.cx;
  assign out_center_y_o = head.box.cy;
  assign out_width_o    = head.box.w;
  assign out_height_o   = head.box.h;
  assign out_score_o    = head.box.score;
  assign out_class_o    = head.box.cls;
  assign end_of_list_o  = head.eol;
  assign none_kept_o    = head.none;
  assign overflowed_o   = head.ovf;

endmodule
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
module testbench;
  import snm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 150000;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    box_t box;
    logic last;
  } cand_t;

  // predicts the surviving boxes of each frame and checks the result words
  class nms_scoreboard;
    logic [15:0] score_thr;
    logic signed [15:0] ovl_thr;
    logic agnostic;
    box_t store[MAX_BOXES];
    int kept;
    logic ovf;
    res_t expect_q[$];
    int errors;

    function new();
      score_thr = SCORE_THR_RST;
      ovl_thr = OVL_THR_RST;
      agnostic = 1'b0;
      kept = 0;
      ovf = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_SCORE_THR: score_thr = val[15:0];
        REG_OVL_THR: ovl_thr = val[15:0];
        REG_AGNOSTIC: agnostic = val[0];
        default: ;
      endcase
    endfunction

    function bit diou_over(box_t a, box_t b);
      longint la, ra, ta, ba, lb, rb, tb, bb, iw, ih, inter, uni, cw, ch, dx, dy;
      bit [127:0] p, q, tt, w_inter, w_uni, w_cd, w_dist;
      int t;
      t = ovl_thr;
      la = 2 * longint'(a.cx) - a.w;
      ra = 2 * longint'(a.cx) + a.w;
      ta = 2 * longint'(a.cy) - a.h;
      ba = 2 * longint'(a.cy) + a.h;
      lb = 2 * longint'(b.cx) - b.w;
      rb = 2 * longint'(b.cx) + b.w;
      tb = 2 * longint'(b.cy) - b.h;
      bb = 2 * longint'(b.cy) + b.h;
      iw = ((ra < rb) ? ra : rb) - ((la > lb) ? la : lb);
      ih = ((ba < bb) ? ba : bb) - ((ta > tb) ? ta : tb);
      if (iw < 0 || ih < 0) return t < 0;
      inter = iw * ih;
      uni = 4 * longint'(a.w) * a.h + 4 * longint'(b.w) * b.h - inter;
      if (uni == 0) return t < 0;
      cw = ((ra > rb) ? ra : rb) - ((la < lb) ? la : lb);
      ch = ((ba > bb) ? ba : bb) - ((ta < tb) ? ta : tb);
      dx = 2 * (longint'(a.cx) - b.cx);
      dy = 2 * (longint'(a.cy) - b.cy);
      w_inter = inter;
      w_uni = uni;
      w_cd = cw * cw + ch * ch;
      w_dist = dx * dx + dy * dy;
      p = w_inter * 32768 * w_cd;
      q = w_dist * 32768 * w_uni;
      tt = (t >= 0) ? t : -t;
      if (t >= 0) q = q + tt * w_uni * w_cd;
      else p = p + tt * w_uni * w_cd;
      return p > q;
    endfunction

    function void note_input(cand_t c);
      int order[MAX_BOXES];
      bit gone[MAX_BOXES];
      int k, cnt;
      res_t r;
      if (c.box.score != 0 && c.box.score >= score_thr) begin
        if (kept < MAX_BOXES) begin
          store[kept] = c.box;
          kept++;
        end else begin
          ovf = 1'b1;
        end
      end
      if (!c.last) return;
      // stable descending sort by score
      for (int i = 0; i < kept; i++) begin
        k = i;
        while (k > 0 && store[order[k-1]].score < store[i].score) begin
          order[k] = order[k-1];
          k--;
        end
        order[k] = i;
        gone[i] = 1'b0;
      end
      for (int i = 0; i < kept; i++) begin
        if (!gone[order[i]]) begin
          for (int j = i + 1; j < kept; j++) begin
            if (!gone[order[j]] &&
                (store[order[i]].cls == store[order[j]].cls || agnostic) &&
                diou_over(store[order[i]], store[order[j]]))
              gone[order[j]] = 1'b1;
          end
        end
      end
      cnt = 0;
      for (int i = 0; i < kept; i++) begin
        if (!gone[order[i]]) begin
          r = '0;
          r.box = store[order[i]];
          r.ovf = ovf;
          expect_q = {expect_q, r};
          cnt++;
        end
      end
      if (cnt == 0) begin
        r = '0;
        r.none = 1'b1;
        r.ovf = ovf;
        expect_q = {expect_q, r};
      end
      expect_q[expect_q.size()-1].eol = 1'b1;
      kept = 0;
      ovf = 1'b0;
    endfunction

    function void check(res_t got);
      res_t want;
      if (expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %p", got);
        return;
      end
      want = expect_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("word mismatch:\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0, pop = 1'b0;
  logic full, empty;
  logic [15:0] center_x_i = '0, center_y_i = '0, box_width_i = '0, box_height_i = '0;
  logic [15:0] score_i = '0;
  logic [7:0] class_id_i = '0;
  logic last_i = 1'b0;
  logic [15:0] out_center_x_o, out_center_y_o, out_width_o, out_height_o, out_score_o;
  logic [7:0] out_class_o;
  logic end_of_list_o, none_kept_o, overflowed_o;

  nms_scoreboard sb = new();
  int idle_cycles = 0;
  int items_sent = 0;
  bit hold_rx = 1'b0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  score_filter_diou_nms i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .center_x_i, .center_y_i, .box_width_i, .box_height_i, .score_i,
    .class_id_i, .last_i, .empty, .pop, .out_center_x_o, .out_center_y_o,
    .out_width_o, .out_height_o, .out_score_o, .out_class_o, .end_of_list_o,
    .none_kept_o, .overflowed_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("score_filter_diou_nms test failed");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(logic [15:0] thr, logic [15:0] ovl, logic agn);
    reg_write(REG_SCORE_THR, {16'd0, thr});
    reg_write(REG_OVL_THR, {16'd0, ovl});
    reg_write(REG_AGNOSTIC, {31'd0, agn});
  endtask

  task automatic send_box(box_t b, logic lst);
    int gap;
    cand_t c;
    if ($urandom_range(0, 30) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    c.box = b;
    c.last = lst;
    center_x_i <= b.cx;
    center_y_i <= b.cy;
    box_width_i <= b.w;
    box_height_i <= b.h;
    score_i <= b.score;
    class_id_i <= b.cls;
    last_i <= lst;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    sb.note_input(c);
    items_sent++;
  endtask

  function automatic box_t make_box(logic [15:0] cx, logic [15:0] cy, logic [15:0] w,
                                    logic [15:0] h, logic [15:0] sc, logic [7:0] cl);
    box_t b;
    b.cx = cx; b.cy = cy; b.w = w; b.h = h; b.score = sc; b.cls = cl;
    return b;
  endfunction

  // boxes of a frame cluster around one spot so that many pairs overlap
  task automatic random_frame(int n);
    logic [15:0] bx, by;
    box_t b;
    bx = 16'($urandom);
    by = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        b = make_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 8'($urandom));
      end else begin
        b.cx = 16'(bx + $urandom_range(0, 255) - 128);
        b.cy = 16'(by + $urandom_range(0, 255) - 128);
        b.w = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(16, 3000));
        b.h = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(16, 3000));
        b.score = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 2)) : 16'($urandom);
        b.cls = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
      end
      send_box(b, i == n - 1);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni) break;
    end
    forever begin
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      if ($urandom_range(0, 30) == 0) rx_burst = !rx_burst;
      if (!rx_burst && $urandom_range(0, 3) != 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check('{box: '{cx: out_center_x_o, cy: out_center_y_o, w: out_width_o,
                        h: out_height_o, score: out_score_o, cls: out_class_o},
                 eol: end_of_list_o, none: none_kept_o, ovf: overflowed_o});
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames at reset settings
    send_box(make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 8'h00), 1'b0);
    send_box(make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE, 8'h00), 1'b0);
    send_box(make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 8'hFF), 1'b0);
    send_box(make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 8'hFF), 1'b0);
    send_box(make_box(16'h0100, 16'h0100, 16'h0040, 16'h0040, 16'h7000, 8'h05), 1'b0);
    // touching edge on the right
    send_box(make_box(16'h0140, 16'h0100, 16'h0040, 16'h0040, 16'h6000, 8'h05), 1'b0);
    send_box(make_box(16'h0100, 16'h0100, 16'h0040, 16'h0040, 16'h6000, 8'h06), 1'b0);
    send_box(make_box(16'h1234, 16'h4321, 16'h0200, 16'h0200, 16'h0000, 8'h05), 1'b0);
    send_box(make_box(16'h1234, 16'h4321, 16'h0200, 16'h0200, 16'h3FFF, 8'h05), 1'b0);
    send_box(make_box(16'h0800, 16'h0800, 16'h0300, 16'h0100, 16'h4000, 8'hAA), 1'b1);
    // nothing kept
    send_box(make_box(16'h0500, 16'h0500, 16'h0100, 16'h0100, 16'h0001, 8'h01), 1'b0);
    send_box(make_box(16'h0500, 16'h0500, 16'h0100, 16'h0100, 16'h0000, 8'h01), 1'b1);
    drain();

    set_config(16'h0000, 16'h8000, 1'b1);
    send_box(make_box(16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 8'h01), 1'b0);
    send_box(make_box(16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0001, 8'h01), 1'b0);
    send_box(make_box(16'h9000, 16'h9000, 16'h0010, 16'h0010, 16'h0002, 8'h02), 1'b0);
    send_box(make_box(16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0001, 8'h03), 1'b1);
    random_frame(5);
    drain();

    set_config(16'hFFFF, 16'h7FFF, 1'b0);
    send_box(make_box(16'h0100, 16'h0100, 16'h0040, 16'h0040, 16'hFFFF, 8'h01), 1'b0);
    send_box(make_box(16'h0100, 16'h0100, 16'h0040, 16'h0040, 16'hFFFF, 8'h01), 1'b0);
    send_box(make_box(16'h0100, 16'h0100, 16'h0040, 16'h0040, 16'hFFFE, 8'h01), 1'b1);
    drain();

    // random phases
    for (int ph = 0; ph < 6 && items_sent < 450; ph++) begin
      case (ph)
        0: set_config(SCORE_THR_RST, OVL_THR_RST, 1'b0);
        1: set_config(16'h0000, 16'h0000, 1'b1);
        2: set_config(16'h2000, 16'hC000, 1'b0);
        default: set_config(16'($urandom_range(0, 16'h6000)), 16'($urandom),
                            1'($urandom_range(0, 1)));
      endcase
      if (ph == 0) random_frame(70);
      if (ph == 1) begin
        hold_rx = 1'b1;
        repeat (4) random_frame($urandom_range(4, 10));
      end
      repeat (18) begin
        if (items_sent < 450) random_frame($urandom_range(1, 8));
      end
      drain();
    end

    if (sb.errors == 0 && sb.expect_q.size() == 0) begin
      $display("score_filter_diou_nms test passed");
    end else begin
      $display("score_filter_diou_nms test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
